/* src/frt_pkg.sv */
// Fragment reassembly tracker: shared types, codes and default sizes.
// Used by the controller, the datapath, the top level and the bench.
`timescale 1ns / 1ps

package frt_pkg;

  // default table geometry
  localparam int DEF_SLOT_COUNT    = 31;
  localparam int DEF_MAX_FRAGMENTS = 256;
  // most requests that one scan emits
  localparam int SCAN_CAP          = 64;

  // operation codes
  localparam logic [1:0] OP_FRAG = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_SCAN = 2'd2;

  // result status codes
  localparam logic [2:0] ST_STORED        = 3'd0;
  localparam logic [2:0] ST_DUPLICATE     = 3'd1;
  localparam logic [2:0] ST_IGNORED       = 3'd2;
  localparam logic [2:0] ST_BAD_INDEX     = 3'd3;
  localparam logic [2:0] ST_POPPED        = 3'd4;
  localparam logic [2:0] ST_NONE_COMPLETE = 3'd5;
  localparam logic [2:0] ST_REQUEST       = 3'd6;
  localparam logic [2:0] ST_NONE_MISSING  = 3'd7;

  // one result item, without its last flag
  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  slot_index;
    logic [15:0] msg_id;
    logic [7:0]  fragment_index;
    logic [7:0]  fragment_total;
    logic        message_complete;
    logic        evicted_other;
  } frt_res_t;

  // controller -> datapath
  typedef struct packed {
    logic       capture;
    logic       mod_mul;
    logic       mod_qn;
    logic       mod_rem;
    logic       idx_clr;
    logic       idx_inc;
    logic       mem_rd;
    logic       frag_upd;
    logic       pop_take;
    logic       code_ld;
    logic [2:0] code;
    logic       scan_init;
    logic       j_clr;
    logic       j_inc;
    logic       req_load;
    logic       emit;
    logic       emit_last;
  } frt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic idx_last;
    logic cur_valid;
    logic cur_complete;
    logic j_end;
    logic bit_set;
    logic n_full;
    logic have_pend;
    logic out_free;
  } frt_stat_t;

endpackage

/* src/frt_in_if.sv */
// Input channel of the fragment reassembly tracker: valid/ready plus item fields.
// Depends on nothing but its own declarations.
`timescale 1ns / 1ps

interface frt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [15:0] msg_id;
  logic [7:0] fragment_index;
  logic [7:0] fragment_total;
  logic       is_data;
  logic [6:0] request_limit;

  modport source (output valid, operation, msg_id, fragment_index, fragment_total,
                  is_data, request_limit, input ready);
  modport sink   (input valid, operation, msg_id, fragment_index, fragment_total,
                  is_data, request_limit, output ready);
endinterface

/* src/frt_out_if.sv */
// Result channel of the fragment reassembly tracker: valid/ready plus result fields.
// Depends on nothing but its own declarations.
`timescale 1ns / 1ps

interface frt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [4:0]  slot_index;
  logic [15:0] result_msg_id;
  logic [7:0]  result_fragment_index;
  logic [7:0]  result_fragment_total;
  logic        message_complete;
  logic        evicted_other;
  logic        last_result;

  modport source (output valid, status, slot_index, result_msg_id,
                  result_fragment_index, result_fragment_total, message_complete,
                  evicted_other, last_result, input ready);
  modport sink   (input valid, status, slot_index, result_msg_id,
                  result_fragment_index, result_fragment_total, message_complete,
                  evicted_other, last_result, output ready);
endinterface

/* src/frt_dp.sv */
// Datapath of the fragment reassembly tracker: slot table, bitmap memory,
// slot-number reduction, scan counters and output register. Uses frt_pkg.
`timescale 1ns / 1ps

module frt_dp #(
  parameter int SLOT_COUNT    = frt_pkg::DEF_SLOT_COUNT,
  parameter int MAX_FRAGMENTS = frt_pkg::DEF_MAX_FRAGMENTS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [15:0]      in_msg_id,
  input  logic [7:0]       in_fragment_index,
  input  logic [7:0]       in_fragment_total,
  input  logic [6:0]       in_request_limit,
  input  frt_pkg::frt_cmd_t cmd,
  output frt_pkg::frt_stat_t stat,
  input  logic             out_ready,
  output logic             out_valid,
  output frt_pkg::frt_res_t out_res,
  output logic             out_last
);
  import frt_pkg::*;

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int FW = $clog2(MAX_FRAGMENTS);
  localparam int RS = 24;
  // floor(2^24 / SLOT_COUNT): quotient estimate is low by at most one
  localparam logic [23:0] RECIP = 24'((64'd1 << RS) / SLOT_COUNT);

  // captured item
  logic [15:0] id_r;
  logic [7:0]  fidx_r;
  logic [7:0]  ftot_r;
  logic [6:0]  lim_r;

  // slot reduction and walk counters
  logic [39:0]   prod_r;
  logic [15:0]   qn_r;
  logic [SW-1:0] idx_r;
  logic [7:0]    j_r;
  logic [6:0]    n_r;
  logic          have_pend_r;

  // slot table
  logic          sv_r   [SLOT_COUNT];
  logic [15:0]   sid_r  [SLOT_COUNT];
  logic [7:0]    stot_r [SLOT_COUNT];
  logic [7:0]    scnt_r [SLOT_COUNT];

  // bitmap rows, one per slot
  logic [MAX_FRAGMENTS-1:0] mem [SLOT_COUNT];
  logic [MAX_FRAGMENTS-1:0] row_r;

  // pending result and output register
  frt_res_t res_r;
  frt_res_t out_res_r;
  logic     out_valid_r;
  logic     out_last_r;

  // current slot view
  logic        cur_valid;
  logic [15:0] cur_id;
  logic [7:0]  cur_tot;
  logic [7:0]  cur_cnt;
  logic        out_free;

  assign cur_valid = sv_r[idx_r];
  assign cur_id    = sid_r[idx_r];
  assign cur_tot   = stot_r[idx_r];
  assign cur_cnt   = scnt_r[idx_r];
  assign out_free  = !out_valid_r || out_ready;

  // remainder correction
  logic [15:0] rem_raw;
  logic [15:0] rem_fix;
  assign rem_raw = id_r - qn_r;
  assign rem_fix = (rem_raw >= 16'(SLOT_COUNT)) ? rem_raw - 16'(SLOT_COUNT) : rem_raw;

  // fragment update decode
  logic                     same;
  logic [7:0]               tot_lim;
  logic [7:0]               total;
  logic                     bad;
  logic [FW-1:0]            bitpos;
  logic [MAX_FRAGMENTS-1:0] onehot;
  logic                     dup;
  logic [7:0]               cnt_new;
  logic                     mem_we;
  logic [MAX_FRAGMENTS-1:0] mem_wdata;
  frt_res_t                 frag_res;

  always_comb begin
    same     = cur_valid && (cur_id == id_r);
    tot_lim  = ({1'b0, ftot_r} > 9'(MAX_FRAGMENTS)) ? 8'(MAX_FRAGMENTS) : ftot_r;
    total    = same ? cur_tot : tot_lim;
    bad      = (fidx_r >= total) || ({1'b0, fidx_r} >= 9'(MAX_FRAGMENTS));
    bitpos   = fidx_r[FW-1:0];
    onehot   = {{(MAX_FRAGMENTS-1){1'b0}}, 1'b1} << bitpos;
    dup      = same && row_r[bitpos];
    cnt_new  = same ? (dup ? cur_cnt : cur_cnt + 8'd1) : 8'd1;
    mem_we    = cmd.frag_upd && !bad && !dup;
    mem_wdata = same ? (row_r | onehot) : onehot;

    frag_res                = '0;
    frag_res.slot_index     = 5'(idx_r);
    frag_res.msg_id         = id_r;
    frag_res.fragment_index = fidx_r;
    frag_res.fragment_total = total;
    if (bad) begin
      frag_res.status = ST_BAD_INDEX;
    end else begin
      frag_res.status           = dup ? ST_DUPLICATE : ST_STORED;
      frag_res.message_complete = (cnt_new == total);
      frag_res.evicted_other    = !same && cur_valid;
    end
  end

  // status to controller
  always_comb begin
    stat.idx_last     = (idx_r == SW'(SLOT_COUNT - 1));
    stat.cur_valid    = cur_valid;
    stat.cur_complete = cur_valid && (cur_cnt == cur_tot);
    stat.j_end        = (j_r >= cur_tot);
    stat.bit_set      = row_r[j_r[FW-1:0]];
    stat.n_full       = (n_r >= lim_r);
    stat.have_pend    = have_pend_r;
    stat.out_free     = out_free;
  end

  // bitmap memory: one port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx_r] <= mem_wdata;
    end
    if (cmd.mem_rd) begin
      row_r <= mem[idx_r];
    end
  end

  // control state and slot valid/count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      have_pend_r <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        sv_r[i]   <= 1'b0;
        scnt_r[i] <= 8'd0;
      end
    end else begin
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.scan_init) begin
        have_pend_r <= 1'b0;
      end else if (cmd.req_load) begin
        have_pend_r <= 1'b1;
      end
      if (mem_we) begin
        sv_r[idx_r]   <= 1'b1;
        scnt_r[idx_r] <= cnt_new;
      end
      if (cmd.pop_take) begin
        sv_r[idx_r]   <= 1'b0;
        scnt_r[idx_r] <= 8'd0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      id_r   <= in_msg_id;
      fidx_r <= in_fragment_index;
      ftot_r <= in_fragment_total;
      lim_r  <= (in_request_limit > 7'(SCAN_CAP)) ? 7'(SCAN_CAP) : in_request_limit;
    end
    // slot = id mod SLOT_COUNT by reciprocal multiply
    if (cmd.mod_mul) begin
      prod_r <= {24'd0, id_r} * {16'd0, RECIP};
    end
    if (cmd.mod_qn) begin
      qn_r <= 16'(prod_r[39:24] * 16'(SLOT_COUNT));
    end
    if (cmd.mod_rem) begin
      idx_r <= SW'(rem_fix);
    end else if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + SW'(1);
    end
    if (cmd.j_clr) begin
      j_r <= 8'd0;
    end else if (cmd.j_inc) begin
      j_r <= j_r + 8'd1;
    end
    if (cmd.scan_init) begin
      n_r <= 7'd0;
    end else if (cmd.req_load) begin
      n_r <= n_r + 7'd1;
    end
    if (mem_we && !same) begin
      sid_r[idx_r]  <= id_r;
      stot_r[idx_r] <= total;
    end
    // pending result
    if (cmd.code_ld) begin
      res_r <= '{status: cmd.code, slot_index: 5'd0, msg_id: 16'd0,
                 fragment_index: 8'd0, fragment_total: 8'd0,
                 message_complete: 1'b0, evicted_other: 1'b0};
    end else if (cmd.frag_upd) begin
      res_r <= frag_res;
    end else if (cmd.pop_take) begin
      res_r <= '{status: ST_POPPED, slot_index: 5'(idx_r), msg_id: cur_id,
                 fragment_index: 8'd0, fragment_total: cur_tot,
                 message_complete: 1'b1, evicted_other: 1'b0};
    end else if (cmd.req_load) begin
      res_r <= '{status: ST_REQUEST, slot_index: 5'(idx_r), msg_id: cur_id,
                 fragment_index: j_r, fragment_total: cur_tot,
                 message_complete: 1'b0, evicted_other: 1'b0};
    end
    if (cmd.emit) begin
      out_res_r  <= res_r;
      out_last_r <= cmd.emit_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_last  = out_last_r;

endmodule

/* src/frt_ctrl.sv */
// Controller of the fragment reassembly tracker: sequences fragment updates,
// pop and scan walks over the datapath. Uses frt_pkg.
`timescale 1ns / 1ps

module frt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_operation,
  input  logic              in_is_data,
  output logic              in_ready,
  input  frt_pkg::frt_stat_t stat,
  output frt_pkg::frt_cmd_t  cmd
);
  import frt_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MOD1  = 4'd1;
  localparam logic [3:0] S_MOD2  = 4'd2;
  localparam logic [3:0] S_MOD3  = 4'd3;
  localparam logic [3:0] S_FRD   = 4'd4;
  localparam logic [3:0] S_FWR   = 4'd5;
  localparam logic [3:0] S_POP   = 4'd6;
  localparam logic [3:0] S_SSLOT = 4'd7;
  localparam logic [3:0] S_SBITS = 4'd8;
  localparam logic [3:0] S_SEND  = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_operation == OP_FRAG && in_is_data) begin
            state_nxt = S_MOD1;
          end else if (in_operation == OP_POP) begin
            cmd.idx_clr = 1'b1;
            state_nxt   = S_POP;
          end else if (in_operation == OP_SCAN) begin
            cmd.idx_clr   = 1'b1;
            cmd.scan_init = 1'b1;
            state_nxt     = S_SSLOT;
          end else begin
            cmd.code_ld = 1'b1;
            cmd.code    = ST_IGNORED;
            state_nxt   = S_EMIT;
          end
        end
      end
      // slot number in three registered steps
      S_MOD1: begin
        cmd.mod_mul = 1'b1;
        state_nxt   = S_MOD2;
      end
      S_MOD2: begin
        cmd.mod_qn = 1'b1;
        state_nxt  = S_MOD3;
      end
      S_MOD3: begin
        cmd.mod_rem = 1'b1;
        state_nxt   = S_FRD;
      end
      // read-modify-write of the slot's bitmap row
      S_FRD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_FWR;
      end
      S_FWR: begin
        cmd.frag_upd = 1'b1;
        state_nxt    = S_EMIT;
      end
      // walk for the lowest complete slot
      S_POP: begin
        if (stat.cur_complete) begin
          cmd.pop_take = 1'b1;
          state_nxt    = S_EMIT;
        end else if (stat.idx_last) begin
          cmd.code_ld = 1'b1;
          cmd.code    = ST_NONE_COMPLETE;
          state_nxt   = S_EMIT;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      // scan: pick the next incomplete slot
      S_SSLOT: begin
        if (stat.n_full) begin
          state_nxt = S_SEND;
        end else if (stat.cur_valid && !stat.cur_complete) begin
          cmd.mem_rd = 1'b1;
          cmd.j_clr  = 1'b1;
          state_nxt  = S_SBITS;
        end else if (stat.idx_last) begin
          state_nxt = S_SEND;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      // scan: a bit per cycle unless output stalls; one request held back
      S_SBITS: begin
        if (stat.j_end || stat.n_full) begin
          if (stat.idx_last) begin
            state_nxt = S_SEND;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_SSLOT;
          end
        end else if (stat.bit_set) begin
          cmd.j_inc = 1'b1;
        end else if (!stat.have_pend || stat.out_free) begin
          cmd.emit     = stat.have_pend;
          cmd.req_load = 1'b1;
          cmd.j_inc    = 1'b1;
        end
      end
      S_SEND: begin
        if (!stat.have_pend) begin
          cmd.code_ld = 1'b1;
          cmd.code    = ST_NONE_MISSING;
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* src/fragment_reassembly_tracker_top.sv */
// Fragment reassembly tracker, top level: controller plus datapath.
// Depends on frt_pkg, frt_in_if, frt_out_if, frt_ctrl and frt_dp.
//
// Usage: items enter on in_ch (valid/ready); results leave on out_ch, one or more
// per item, the final one flagged by last_result. Fragment headers (operation 0)
// update the slot at the message id mod SLOT_COUNT; pop (1) frees the lowest
// complete slot; scan (2) lists missing fragments up to request_limit (max 64).
// One item is worked at a time; in_ch.ready is high only while the block idles.
// Sequence: a fragment header runs a three-step reciprocal reduction of the
// id, then a read-modify-write of one bitmap row. A pop walks one slot per
// cycle up to the lowest complete slot. A scan visits one slot per cycle and,
// in an incomplete slot, one fragment bit per cycle unless a held request waits
// for the output register, so its length follows the stored totals.
// Reset: slots read empty right after reset; no clearing pass is run, since a
// bitmap row is rewritten whole when its slot is taken. The block is ready
// as soon as reset is released.
// Stall: one output register holds results; while out_ch.ready is low the block
// holds back the next result, but takes a new item while a final one waits.
`timescale 1ns / 1ps

module fragment_reassembly_tracker_top #(
  parameter int SLOT_COUNT    = frt_pkg::DEF_SLOT_COUNT,
  parameter int MAX_FRAGMENTS = frt_pkg::DEF_MAX_FRAGMENTS
) (
  input  logic      clk,
  input  logic      rst_n,
  frt_in_if.sink    in_ch,
  frt_out_if.source out_ch
);
  import frt_pkg::*;

  frt_cmd_t  cmd;
  frt_stat_t stat;
  frt_res_t  out_res;
  logic      out_last;
  logic      out_valid;

  frt_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_operation (in_ch.operation),
    .in_is_data   (in_ch.is_data),
    .in_ready     (in_ch.ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  frt_dp #(
    .SLOT_COUNT    (SLOT_COUNT),
    .MAX_FRAGMENTS (MAX_FRAGMENTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_msg_id         (in_ch.msg_id),
    .in_fragment_index (in_ch.fragment_index),
    .in_fragment_total (in_ch.fragment_total),
    .in_request_limit  (in_ch.request_limit),
    .cmd               (cmd),
    .stat              (stat),
    .out_ready         (out_ch.ready),
    .out_valid         (out_valid),
    .out_res           (out_res),
    .out_last          (out_last)
  );

  // result channel
  assign out_ch.valid                 = out_valid;
  assign out_ch.status                = out_res.status;
  assign out_ch.slot_index            = out_res.slot_index;
  assign out_ch.result_msg_id         = out_res.msg_id;
  assign out_ch.result_fragment_index = out_res.fragment_index;
  assign out_ch.result_fragment_total = out_res.fragment_total;
  assign out_ch.message_complete      = out_res.message_complete;
  assign out_ch.evicted_other         = out_res.evicted_other;
  assign out_ch.last_result           = out_last;

endmodule

/* verif/tb.sv */
// Self-checking bench for the fragment reassembly tracker top level.
// Depends on frt_pkg, frt_in_if, frt_out_if and fragment_reassembly_tracker_top.
// A local table model predicts every result item, and a monitor checks them in order.
`timescale 1ns / 1ps

module tb;
  import frt_pkg::*;

  localparam int NSLOT    = DEF_SLOT_COUNT;
  localparam int NFRAG    = DEF_MAX_FRAGMENTS;
  localparam int CYC_MAX  = 600000;
  localparam int NRAND    = 180;
  localparam int ID_POOL  = 40;

  // one input item
  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] id;
    logic [7:0]  fidx;
    logic [7:0]  ftot;
    logic        data;
    logic [6:0]  limit;
  } frag_item_t;

  // one result item with its last flag
  typedef struct packed {
    frt_res_t r;
    logic     last;
  } reasm_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  frt_in_if  in_ch ();
  frt_out_if out_ch ();

  fragment_reassembly_tracker_top u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #10 clk = ~clk;

  // table model state
  logic        tbl_valid [NSLOT];
  logic [15:0] tbl_id    [NSLOT];
  logic [7:0]  tbl_total [NSLOT];
  int          tbl_count [NSLOT];
  logic        tbl_bits  [NSLOT][NFRAG];

  frag_item_t  pend_q[$];
  reasm_res_t  want_q[$];
  logic        offering = 1'b0;
  int          tx_idle = 0;
  int          rx_stall = 0;
  int          rx_hold = 0;
  int          errors = 0;
  int          cycles = 0;
  logic [15:0] pool_id  [ID_POOL];
  logic [7:0]  pool_tot [ID_POOL];

  task automatic report(input string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  function automatic frt_res_t mk_res(logic [2:0] st, int s, logic [15:0] id, logic [7:0] fi,
                                      logic [7:0] ft, logic done, logic ev);
    frt_res_t r;
    r.status = st;
    r.slot_index = 5'(s);
    r.msg_id = id;
    r.fragment_index = fi;
    r.fragment_total = ft;
    r.message_complete = done;
    r.evicted_other = ev;
    return r;
  endfunction

  function automatic logic slot_done(int s);
    return tbl_valid[s] && tbl_count[s] == int'(tbl_total[s]);
  endfunction

  // work out the results of one accepted item and update the table
  task automatic track_item(input frag_item_t it);
    frt_res_t res[$];
    int       s;
    int       tot;
    int       lim;
    logic     same;
    logic     ev;
    s = int'(it.id) % NSLOT;
    case (it.op)
      OP_FRAG: begin
        same = tbl_valid[s] && tbl_id[s] == it.id;
        tot = same ? int'(tbl_total[s]) : int'(it.ftot);
        if (!it.data) begin
          res.push_back(mk_res(ST_IGNORED, 0, 0, 0, 0, 0, 0));
        end else if (int'(it.fidx) >= tot) begin
          res.push_back(mk_res(ST_BAD_INDEX, s, it.id, it.fidx, 8'(tot), 0, 0));
        end else if (!same) begin
          ev = tbl_valid[s];
          tbl_valid[s] = 1'b1;
          tbl_id[s] = it.id;
          tbl_total[s] = 8'(tot);
          for (int j = 0; j < NFRAG; j++) tbl_bits[s][j] = 1'b0;
          tbl_bits[s][it.fidx] = 1'b1;
          tbl_count[s] = 1;
          res.push_back(mk_res(ST_STORED, s, it.id, it.fidx, 8'(tot), slot_done(s), ev));
        end else if (tbl_bits[s][it.fidx]) begin
          res.push_back(mk_res(ST_DUPLICATE, s, it.id, it.fidx, 8'(tot), slot_done(s), 0));
        end else begin
          tbl_bits[s][it.fidx] = 1'b1;
          tbl_count[s]++;
          res.push_back(mk_res(ST_STORED, s, it.id, it.fidx, 8'(tot), slot_done(s), 0));
        end
      end
      OP_POP: begin
        for (int k = 0; k < NSLOT && res.size() == 0; k++) begin
          if (slot_done(k)) begin
            res.push_back(mk_res(ST_POPPED, k, tbl_id[k], 0, tbl_total[k], 1, 0));
            tbl_valid[k] = 1'b0;
            tbl_count[k] = 0;
          end
        end
        if (res.size() == 0) res.push_back(mk_res(ST_NONE_COMPLETE, 0, 0, 0, 0, 0, 0));
      end
      OP_SCAN: begin
        lim = (int'(it.limit) > SCAN_CAP) ? SCAN_CAP : int'(it.limit);
        for (int k = 0; k < NSLOT && res.size() < lim; k++) begin
          if (tbl_valid[k] && !slot_done(k)) begin
            for (int j = 0; j < int'(tbl_total[k]) && res.size() < lim; j++) begin
              if (!tbl_bits[k][j])
                res.push_back(mk_res(ST_REQUEST, k, tbl_id[k], 8'(j), tbl_total[k], 0, 0));
            end
          end
        end
        if (res.size() == 0) res.push_back(mk_res(ST_NONE_MISSING, 0, 0, 0, 0, 0, 0));
      end
      default: res.push_back(mk_res(ST_IGNORED, 0, 0, 0, 0, 0, 0));
    endcase
    foreach (res[i]) want_q.push_back('{r: res[i], last: (i == res.size() - 1)});
  endtask

  function automatic frag_item_t mk_item(logic [1:0] op, logic [15:0] id, logic [7:0] fi,
                                         logic [7:0] ft, logic data, logic [6:0] lim);
    frag_item_t it;
    it.op = op;
    it.id = id;
    it.fidx = fi;
    it.ftot = ft;
    it.data = data;
    it.limit = lim;
    return it;
  endfunction

  // random item: mostly fragments of pooled messages with random header totals, some pops and scans,
  // the rest noise over the full field ranges
  function automatic frag_item_t rand_item();
    int p;
    int k;
    k = $urandom_range(99);
    p = $urandom_range(ID_POOL - 1);
    if (k < 60)
      return mk_item(OP_FRAG, pool_id[p], 8'($urandom_range(pool_tot[p] - 1)),
                     8'($urandom_range(255)), ($urandom_range(19) != 0), 7'($urandom));
    if (k < 75)
      return mk_item(OP_POP, 16'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                     7'($urandom));
    if (k < 88)
      return mk_item(OP_SCAN, 16'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                     ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(1, 8)));
    return mk_item(2'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                   7'($urandom));
  endfunction

  // sender: offers queued items, idles at random
  always @(posedge clk) begin
    frag_item_t nx;
    logic       take;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        track_item(mk_item(in_ch.operation, in_ch.msg_id, in_ch.fragment_index,
                           in_ch.fragment_total, in_ch.is_data, in_ch.request_limit));
        offering = 1'b0;
      end
      if (!offering) begin
        take = pend_q.size() > 0 && $urandom_range(99) >= tx_idle;
        if (take) begin
          nx = pend_q.pop_front();
          in_ch.operation      <= nx.op;
          in_ch.msg_id         <= nx.id;
          in_ch.fragment_index <= nx.fidx;
          in_ch.fragment_total <= nx.ftot;
          in_ch.is_data        <= nx.data;
          in_ch.request_limit  <= nx.limit;
          offering = 1'b1;
        end
        in_ch.valid <= take;
      end
    end
  end

  // long receiver hold-off, counted down here
  always @(posedge clk) begin
    if (rx_hold > 0) rx_hold <= rx_hold - 1;
  end

  // receiver: checks each accepted result against the oldest prediction
  always @(posedge clk) begin
    reasm_res_t w;
    frt_res_t   got;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = mk_res(out_ch.status, out_ch.slot_index, out_ch.result_msg_id,
                     out_ch.result_fragment_index, out_ch.result_fragment_total,
                     out_ch.message_complete, out_ch.evicted_other);
        if (want_q.size() == 0) begin
          report($sformatf("unexpected result %p", got));
        end else begin
          w = want_q.pop_front();
          if (got !== w.r || out_ch.last_result !== w.last)
            report($sformatf("got %p last %b, want %p last %b", got, out_ch.last_result,
                             w.r, w.last));
        end
      end
      out_ch.ready <= (rx_hold <= 1) && ($urandom_range(99) >= rx_stall);
    end
  end

  // run length guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic drain();
    while (pend_q.size() > 0 || offering || want_q.size() > 0) @(posedge clk);
  endtask

  task automatic phase(input int tx, input int rx, input int n);
    tx_idle = tx;
    rx_stall = rx;
    repeat (n) pend_q.push_back(rand_item());
    drain();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = OP_FRAG;
    in_ch.msg_id = '0;
    in_ch.fragment_index = '0;
    in_ch.fragment_total = '0;
    in_ch.is_data = 1'b0;
    in_ch.request_limit = '0;
    out_ch.ready = 1'b0;
    for (int s = 0; s < NSLOT; s++) begin
      tbl_valid[s] = 1'b0;
      tbl_count[s] = 0;
      for (int j = 0; j < NFRAG; j++) tbl_bits[s][j] = 1'b0;
    end
    for (int p = 0; p < ID_POOL; p++) begin
      pool_id[p] = 16'($urandom);
      pool_tot[p] = 8'($urandom_range(1, 6));
    end
    pool_tot[0] = 8'($urandom_range(20, 255));
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, ignored types, bad indexes, eviction, duplicates, scan limits
    pend_q.push_back(mk_item(OP_POP, 0, 0, 0, 1, 1));
    pend_q.push_back(mk_item(OP_SCAN, 0, 0, 0, 1, 64));
    pend_q.push_back(mk_item(OP_FRAG, 16'd5, 0, 3, 0, 0));
    pend_q.push_back(mk_item(2'd3, 16'hffff, 8'hff, 8'hff, 1, 7'h7f));
    pend_q.push_back(mk_item(OP_FRAG, 16'd0, 0, 0, 1, 0));
    pend_q.push_back(mk_item(OP_FRAG, 16'hffff, 8'hff, 8'hff, 1, 0));
    pend_q.push_back(mk_item(OP_FRAG, 16'hffff, 8'hfe, 8'hff, 1, 0));
    pend_q.push_back(mk_item(OP_FRAG, 16'd0, 0, 1, 1, 0));
    pend_q.push_back(mk_item(OP_FRAG, 16'd31, 1, 2, 1, 0));
    pend_q.push_back(mk_item(OP_FRAG, 16'd31, 1, 9, 1, 0));
    pend_q.push_back(mk_item(OP_FRAG, 16'd31, 5, 9, 1, 0));
    pend_q.push_back(mk_item(OP_SCAN, 0, 0, 0, 1, 0));
    pend_q.push_back(mk_item(OP_SCAN, 0, 0, 0, 1, 7'h7f));
    pend_q.push_back(mk_item(OP_SCAN, 0, 0, 0, 0, 1));
    pend_q.push_back(mk_item(OP_FRAG, 16'd31, 0, 9, 1, 0));
    pend_q.push_back(mk_item(OP_POP, 0, 0, 0, 0, 0));
    pend_q.push_back(mk_item(OP_FRAG, 16'd62, 0, 1, 1, 0));
    pend_q.push_back(mk_item(OP_POP, 0, 0, 0, 0, 0));
    pend_q.push_back(mk_item(OP_FRAG, 16'hffff, 0, 3, 0, 0));
    pend_q.push_back(mk_item(OP_SCAN, 0, 0, 0, 1, 64));
    drain();

    // random phases; the receiver blocks for a long stretch while items keep coming
    phase(0, 0, 40);
    rx_hold = 400;
    phase(0, 0, 20);
    phase(47, 0, 40);
    phase(0, 47, 40);
    phase(31, 31, 40);

    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
